>>> design/snd_pkg.sv
// snd_pkg: shared types and constants for the signed non-restoring 64/32 divider
// used by snd_step, the top level signed_nonrestoring_div_64_32 and snd_checker
// no dependencies
package snd_pkg;

  // word width of every operand and of the quotient
  localparam int unsigned Width = 32;
  // number of division steps, one pipeline stage each
  localparam int unsigned Steps = 32;

  // state of one division in flight
  typedef struct packed {
    logic [Width-1:0] lo;   // remaining low dividend bits, shifted left each step
    logic [Width-1:0] hi;   // partial remainder
    logic [Width-1:0] dv;   // divisor
    logic             q;    // previous q bit
    logic             t;    // pending quotient bit
    logic [Width-1:0] acc;  // collected quotient bits
  } step_t;

endpackage

>>> design/snd_step.sv
// snd_step: one non-restoring division step followed by a pipeline register
// depends on snd_pkg (step_t, Width)
module snd_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  snd_pkg::step_t data_i,
  output logic           valid_o,
  output snd_pkg::step_t data_o
);

  logic                     m;
  logic                     top;
  logic [snd_pkg::Width-1:0] hi_shl;
  logic [snd_pkg::Width:0]   sum;
  logic                     cy;
  logic                     q_new;
  snd_pkg::step_t           data_d;
  snd_pkg::step_t           data_q;
  logic                     valid_q;

  // shift the dividend, then subtract or add the divisor
  always_comb begin
    m      = data_i.dv[snd_pkg::Width-1];
    top    = data_i.hi[snd_pkg::Width-1];
    hi_shl = {data_i.hi[snd_pkg::Width-2:0], data_i.lo[snd_pkg::Width-1]};
    if (data_i.q == m) begin
      sum = {1'b0, hi_shl} - {1'b0, data_i.dv};
    end else begin
      sum = {1'b0, hi_shl} + {1'b0, data_i.dv};
    end
    // carry of the add, or borrow of the subtract
    cy     = sum[snd_pkg::Width];
    q_new  = top ^ cy ^ m;

    data_d.lo  = {data_i.lo[snd_pkg::Width-2:0], 1'b0};
    data_d.hi  = sum[snd_pkg::Width-1:0];
    data_d.dv  = data_i.dv;
    data_d.q   = q_new;
    data_d.t   = (q_new == m);
    data_d.acc = {data_i.acc[snd_pkg::Width-2:0], data_i.t};
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> design/signed_nonrestoring_div_64_32.sv
// signed_nonrestoring_div_64_32: fully pipelined raw non-restoring 64/32 divider
// depends on snd_pkg and snd_step
//
//   channel  signals                                          direction
//   in       in_valid_i, in_stall_o, dividend_low_i,
//            dividend_high_i, divisor_i                       request in
//   out      out_valid_o, out_stall_i, quotient_o             request out
//
// one request enters per cycle while no stalled result is held at the output; the
// pipeline has 32 step stages, one add or subtract each, plus the output register
// reset clears all valid bits; payload registers are not reset
// the whole pipeline advances unless the output holds a result that is stalled;
// in_stall_o is raised only then, so no request is dropped or repeated
module signed_nonrestoring_div_64_32 (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic        [snd_pkg::Width-1:0] dividend_low_i,
  input  logic        [snd_pkg::Width-1:0] dividend_high_i,
  input  logic        [snd_pkg::Width-1:0] divisor_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [snd_pkg::Width-1:0] quotient_o
);

  logic                       adv;
  logic                       valid_s [snd_pkg::Steps+1];
  snd_pkg::step_t             data_s  [snd_pkg::Steps+1];
  logic                       out_valid_q;
  logic [snd_pkg::Width-1:0]  quot_d;
  logic [snd_pkg::Width-1:0]  quot_q;

  // global advance: only a stalled output result blocks the pipeline
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // initial q, t from the operand signs
  always_comb begin
    valid_s[0]    = in_valid_i;
    data_s[0].lo  = dividend_low_i;
    data_s[0].hi  = dividend_high_i;
    data_s[0].dv  = divisor_i;
    data_s[0].q   = dividend_high_i[snd_pkg::Width-1];
    data_s[0].t   = dividend_high_i[snd_pkg::Width-1] ^ divisor_i[snd_pkg::Width-1];
    data_s[0].acc = '0;
  end

  // division step stages
  for (genvar i = 0; i < snd_pkg::Steps; i++) begin : g_step
    snd_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (valid_s[i]),
      .data_i  (data_s[i]),
      .valid_o (valid_s[i+1]),
      .data_o  (data_s[i+1])
    );
  end

  // last t bit completes the quotient
  assign quot_d = {data_s[snd_pkg::Steps].acc[snd_pkg::Width-2:0],
                   data_s[snd_pkg::Steps].t};

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_s[snd_pkg::Steps];
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      quot_q <= quot_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign quotient_o  = signed'(quot_q);

endmodule

>>> design/snd_checker.sv
// snd_checker: port-level assertions for signed_nonrestoring_div_64_32
// depends on snd_pkg; bound to the top level at the end of this file
module snd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [snd_pkg::Width-1:0] quotient_o
);

  // input stalls exactly when a result is held at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not match blocked output");

  // a stalled result stays valid
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // a stalled result keeps its value
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(quotient_o))
    else $error("quotient changed while stalled");

  // nothing comes out in the first cycle after reset is released
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // while the output holds no result, the pipeline advances and an offered request is not stalled
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && in_valid_i) |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind signed_nonrestoring_div_64_32 snd_checker u_snd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .quotient_o  (quotient_o)
);
